[src/itoa64_pkg.sv]
// ----------------------------------------------------------------------------
// itoa64_pkg: shared types and constants
// Widths and character codes for the signed 64-bit to decimal text converter.
// ----------------------------------------------------------------------------
package itoa64_pkg;

  localparam int MAG_W         = 64;
  localparam int NUM_DIGITS    = 20;
  localparam int BCD_W         = NUM_DIGITS * 4;
  localparam int BITS_PER_STEP = 4;
  localparam int NUM_STEPS     = MAG_W / BITS_PER_STEP;
  localparam int STEP_CNT_W    = $clog2(NUM_STEPS);
  localparam int DIGIT_CNT_W   = $clog2(NUM_DIGITS + 1);
  localparam int CHAR_W        = 6;

  typedef logic [MAG_W-1:0]       mag_t;
  typedef logic [BCD_W-1:0]       bcd_t;
  typedef logic [STEP_CNT_W-1:0]  step_cnt_t;
  typedef logic [DIGIT_CNT_W-1:0] digit_cnt_t;
  typedef logic [CHAR_W-1:0]      char_t;

  localparam char_t CHAR_MINUS = 6'd45;
  localparam char_t CHAR_ZERO  = 6'd48;

endpackage

[src/itoa64_dabble.sv]
// ----------------------------------------------------------------------------
// itoa64_dabble: shift-and-add-3 unit
// Moves BITS_PER_STEP magnitude bits into the BCD register per use, adjusting
// every digit that is 5 or more before each single-bit shift.
// ----------------------------------------------------------------------------
module itoa64_dabble (
  input  itoa64_pkg::bcd_t bcd,
  input  itoa64_pkg::mag_t bin,
  output itoa64_pkg::bcd_t bcd_next,
  output itoa64_pkg::mag_t bin_next
);

  function automatic itoa64_pkg::bcd_t adjust(input itoa64_pkg::bcd_t b);
    itoa64_pkg::bcd_t r;
    r = b;
    for (int d = 0; d < itoa64_pkg::NUM_DIGITS; d++) begin
      if (b[d*4 +: 4] >= 4'd5) begin
        r[d*4 +: 4] = b[d*4 +: 4] + 4'd3;
      end
    end
    return r;
  endfunction

  always_comb begin
    itoa64_pkg::bcd_t b;
    itoa64_pkg::mag_t m;
    b = bcd;
    m = bin;
    for (int s = 0; s < itoa64_pkg::BITS_PER_STEP; s++) begin
      b = adjust(b);
      b = {b[itoa64_pkg::BCD_W-2:0], m[itoa64_pkg::MAG_W-1]};
      m = {m[itoa64_pkg::MAG_W-2:0], 1'b0};
    end
    bcd_next = b;
    bin_next = m;
  end

endmodule

[src/signed_int64_to_decimal_ascii.sv]
// ----------------------------------------------------------------------------
// signed_int64_to_decimal_ascii: signed 64-bit integer to decimal ASCII
// Input channel (in_valid/in_stall) takes one value per transfer. Output
// channel (out_valid/out_stall) gives one character per transfer, most
// significant first, with a leading '-' for negative values and last set on
// the final character. Zero gives the single character '0'; the most
// negative value gives "-9223372036854775808".
// One value is worked on at a time; in_stall is high until the last
// character has moved into the output register. The magnitude is converted
// by one shared shift-and-add-3 unit, four bits per cycle, then leading
// zero digits are dropped one per cycle and the characters are loaded one
// per cycle while the output is not stalled.
// A stalled output holds its character and pauses the emit sequence.
// Reset (rst, synchronous) returns to idle and empties the output register.
// ----------------------------------------------------------------------------
module signed_int64_to_decimal_ascii (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic signed [63:0]    value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output itoa64_pkg::char_t     character,
  output logic                  last
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CONV = 3'd1;
  localparam logic [2:0] ST_SKIP = 3'd2;
  localparam logic [2:0] ST_SIGN = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [2:0]             state;
  logic                   negative;
  itoa64_pkg::bcd_t       bcd;
  itoa64_pkg::mag_t       bin;
  itoa64_pkg::step_cnt_t  step_cnt;
  itoa64_pkg::digit_cnt_t digit_cnt;
  itoa64_pkg::bcd_t       bcd_next;
  itoa64_pkg::mag_t       bin_next;
  itoa64_pkg::mag_t       mag_in;
  logic                   in_xfer;
  logic                   slot_free;
  logic                   load_out;
  logic [3:0]             top_digit;

  assign in_stall  = (state != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign slot_free = !out_valid || !out_stall;
  assign load_out  = slot_free && (state == ST_SIGN || state == ST_EMIT);
  assign top_digit = bcd[itoa64_pkg::BCD_W-1 -: 4];
  assign mag_in    = value[63] ? ($unsigned(~value) + 64'd1) : $unsigned(value);

  itoa64_dabble u_dabble (
    .bcd      (bcd),
    .bin      (bin),
    .bcd_next (bcd_next),
    .bin_next (bin_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            negative  <= value[63];
            bin       <= mag_in;
            bcd       <= '0;
            step_cnt  <= '0;
            digit_cnt <= itoa64_pkg::digit_cnt_t'(itoa64_pkg::NUM_DIGITS);
            state     <= ST_CONV;
          end
        end
        ST_CONV: begin
          bcd      <= bcd_next;
          bin      <= bin_next;
          step_cnt <= step_cnt + 1'b1;
          if (step_cnt == itoa64_pkg::step_cnt_t'(itoa64_pkg::NUM_STEPS - 1)) begin
            state <= ST_SKIP;
          end
        end
        ST_SKIP: begin
          if (top_digit == 4'd0 && digit_cnt != itoa64_pkg::digit_cnt_t'(1)) begin
            bcd       <= {bcd[itoa64_pkg::BCD_W-5:0], 4'd0};
            digit_cnt <= digit_cnt - 1'b1;
          end else begin
            state <= negative ? ST_SIGN : ST_EMIT;
          end
        end
        ST_SIGN: begin
          if (slot_free) begin
            character <= itoa64_pkg::CHAR_MINUS;
            last      <= 1'b0;
            state     <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (slot_free) begin
            character <= itoa64_pkg::CHAR_ZERO + itoa64_pkg::char_t'(top_digit);
            last      <= (digit_cnt == itoa64_pkg::digit_cnt_t'(1));
            bcd       <= {bcd[itoa64_pkg::BCD_W-5:0], 4'd0};
            digit_cnt <= digit_cnt - 1'b1;
            if (digit_cnt == itoa64_pkg::digit_cnt_t'(1)) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_emit_has_digits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT || state == ST_SIGN || state == ST_SKIP) |-> digit_cnt != '0)
    else $error("digit count ran out before the last character");

  a_start_conv: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> (state == ST_CONV && step_cnt == '0))
    else $error("input transfer did not start a conversion");

  a_conv_len: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CONV && step_cnt == itoa64_pkg::step_cnt_t'(itoa64_pkg::NUM_STEPS - 1))
    |=> state == ST_SKIP)
    else $error("conversion did not end after all steps");

  a_last_ends_item: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && slot_free && digit_cnt == itoa64_pkg::digit_cnt_t'(1))
    |=> (state == ST_IDLE && out_valid && last))
    else $error("final character not flagged or sequencer not idle");

endmodule
